>>> sv/cra_pkg.sv
`default_nettype none
package cra_pkg;

  localparam int MAX_HOLES   = 64;
  localparam int MAX_REGIONS = 64;
  localparam int ADDR_BITS   = 20;

  localparam int SIZE_W = ADDR_BITS + 1;
  localparam int HIDX_W = $clog2(MAX_HOLES);
  localparam int RIDX_W = $clog2(MAX_REGIONS);
  localparam int HCNT_W = $clog2(MAX_HOLES + 1);
  localparam int RCNT_W = $clog2(MAX_REGIONS + 1);
  localparam int OWNER_W = 16;
  localparam int HOLE_W = SIZE_W + ADDR_BITS;
  localparam int REG_W  = OWNER_W + SIZE_W + ADDR_BITS;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 21;

  localparam logic [1:0] FN_REQUEST  = 2'd0;
  localparam logic [1:0] FN_RELEASE  = 2'd1;
  localparam logic [1:0] FN_COMPACT  = 2'd2;
  localparam logic [1:0] FN_RESERVED = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_NOOWNER = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE       = 8'hFF;

  localparam logic [SIZE_W-1:0] SPACE_MAX = SIZE_W'(1) << ADDR_BITS;

  typedef enum logic [10:0] {
    S_IDLE      = 11'b000_0000_0001,
    S_REQ_SCAN  = 11'b000_0000_0010,
    S_REQ_UPD   = 11'b000_0000_0100,
    S_REL_RSCAN = 11'b000_0000_1000,
    S_REL_HSCAN = 11'b000_0001_0000,
    S_REG_SHIFT = 11'b000_0010_0000,
    S_HACT      = 11'b000_0100_0000,
    S_HOLE_DROP = 11'b000_1000_0000,
    S_HOLE_INS  = 11'b001_0000_0000,
    S_CMP_SCAN  = 11'b010_0000_0000,
    S_DONE      = 11'b100_0000_0000
  } cra_state_t;

  function automatic logic [SIZE_W-1:0] clamp_total(input logic [CFG_DATA_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = SIZE_W'(v);
    if (v == '0) r = SIZE_W'(1);
    else if (SIZE_W'(v) > SPACE_MAX) r = SPACE_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> sv/contiguous_region_allocator.sv
// A request walks the hole table (and again when the chosen hole is used up), a release the
// region and hole tables, a compaction the region table; an early refusal walks no table.
// Throughput: one item at a time; every table walk goes one entry a cycle through the
// single read port, and the next item is taken in S_IDLE after S_DONE loads the result.
// Reset (and a write of total_size) leaves one hole over the whole space, no regions.
`default_nettype none
module contiguous_region_allocator (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          func,
  input  wire logic [cra_pkg::SIZE_W-1:0]          alloc_size,
  input  wire logic [cra_pkg::OWNER_W-1:0]         owner,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               status,
  output logic [cra_pkg::ADDR_BITS-1:0]            start_address,
  output logic [cra_pkg::SIZE_W-1:0]               free_total,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [cra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [cra_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = cra_pkg::ADDR_BITS;
  localparam int SW = cra_pkg::SIZE_W;
  localparam int HI = cra_pkg::HIDX_W;
  localparam int RI = cra_pkg::RIDX_W;
  localparam int HC = cra_pkg::HCNT_W;
  localparam int RC = cra_pkg::RCNT_W;
  localparam int OW = cra_pkg::OWNER_W;
  localparam int IW = (HC > RC) ? HC : RC;
  localparam int XW = (HI > RI) ? HI : RI;

  cra_pkg::cra_state_t state;

  logic [1:0]    fit_policy;
  logic [SW-1:0] total_size;
  logic [SW-1:0] free_units;
  logic          init_pend;
  logic [HC-1:0] hole_count;
  logic [RC-1:0] region_count;

  logic [IW-1:0] idx;
  logic          rv;
  logic [XW-1:0] ridx;
  logic [HC-1:0] pos;

  logic [SW-1:0] size_q;
  logic [OW-1:0] owner_q;

  logic          found;
  logic [HI-1:0] pick;
  logic [AW-1:0] pstart;
  logic [SW-1:0] psize;
  logic [RI-1:0] rsel;
  logic [AW-1:0] s_reg;
  logic [SW-1:0] sz_reg;
  logic          have_lo, have_hi;
  logic [HI-1:0] lo, hi;
  logic [AW-1:0] lo_start;
  logic [SW-1:0] lo_size, hi_size;
  logic [SW-1:0] next_addr;
  logic [1:0]    res_status;
  logic [AW-1:0] res_addr;

  logic                 hole_we;
  logic [HI-1:0]        hole_waddr, hole_raddr;
  logic [cra_pkg::HOLE_W-1:0] hole_wdata, hole_rdata;
  logic                 reg_we;
  logic [RI-1:0]        reg_waddr, reg_raddr;
  logic [cra_pkg::REG_W-1:0]  reg_wdata, reg_rdata;

  logic [AW-1:0] h_start;
  logic [SW-1:0] h_size;
  logic [AW-1:0] r_start;
  logic [SW-1:0] r_size;
  logic [OW-1:0] r_owner;
  logic          h_fits;
  logic          accept;
  logic          cfg_we;
  logic [IW-1:0] idx_m1;
  logic [SW-1:0] clamped;

  cra_ram #(.WIDTH(cra_pkg::HOLE_W), .DEPTH(cra_pkg::MAX_HOLES)) u_holes (
    .clk(clk), .we(hole_we), .waddr(hole_waddr), .wdata(hole_wdata),
    .raddr(hole_raddr), .rdata(hole_rdata)
  );

  cra_ram #(.WIDTH(cra_pkg::REG_W), .DEPTH(cra_pkg::MAX_REGIONS)) u_regions (
    .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
    .raddr(reg_raddr), .rdata(reg_rdata)
  );

  assign h_start = hole_rdata[AW-1:0];
  assign h_size  = hole_rdata[cra_pkg::HOLE_W-1:AW];
  assign r_start = reg_rdata[AW-1:0];
  assign r_size  = reg_rdata[AW+SW-1:AW];
  assign r_owner = reg_rdata[cra_pkg::REG_W-1:AW+SW];
  assign h_fits  = (h_size >= size_q);
  assign idx_m1  = idx - IW'(1);
  assign clamped = cra_pkg::clamp_total(cfg_data);

  // a pending register write goes first; hold the input off meanwhile
  assign in_stall  = !((state == cra_pkg::S_IDLE) && !init_pend && !cfg_valid);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = (state == cra_pkg::S_IDLE) && !init_pend;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign hole_raddr = (state == cra_pkg::S_HOLE_INS) ? idx_m1[HI-1:0] : idx[HI-1:0];
  assign reg_raddr  = idx[RI-1:0];

  // RAM write ports
  always_comb begin
    hole_we    = 1'b0;
    hole_waddr = '0;
    hole_wdata = '0;
    reg_we     = 1'b0;
    reg_waddr  = '0;
    reg_wdata  = '0;
    case (state)
      cra_pkg::S_IDLE: begin
        if (init_pend) begin
          hole_we    = 1'b1;
          hole_wdata = {total_size, AW'(0)};
        end
      end
      cra_pkg::S_REQ_UPD: begin
        reg_we    = 1'b1;
        reg_waddr = region_count[RI-1:0];
        reg_wdata = {owner_q, size_q, pstart};
        if (psize != size_q) begin
          hole_we    = 1'b1;
          hole_waddr = pick;
          hole_wdata = {psize - size_q, pstart + size_q[AW-1:0]};
        end
      end
      cra_pkg::S_HOLE_DROP: begin
        if (rv) begin
          hole_we    = 1'b1;
          hole_waddr = HI'(ridx - XW'(1));
          hole_wdata = hole_rdata;
        end
      end
      cra_pkg::S_REG_SHIFT: begin
        if (rv) begin
          reg_we    = 1'b1;
          reg_waddr = RI'(ridx - XW'(1));
          reg_wdata = reg_rdata;
        end
      end
      cra_pkg::S_HACT: begin
        if (have_lo) begin
          hole_we    = 1'b1;
          hole_waddr = lo;
          hole_wdata = {lo_size + sz_reg + (have_hi ? hi_size : SW'(0)), lo_start};
        end else if (have_hi) begin
          hole_we    = 1'b1;
          hole_waddr = hi;
          hole_wdata = {hi_size + sz_reg, s_reg};
        end
      end
      cra_pkg::S_HOLE_INS: begin
        if (rv) begin
          hole_we    = 1'b1;
          hole_waddr = HI'(ridx + XW'(1));
          hole_wdata = hole_rdata;
        end else if (idx <= IW'(pos)) begin
          hole_we    = 1'b1;
          hole_waddr = pos[HI-1:0];
          hole_wdata = {sz_reg, s_reg};
        end
      end
      cra_pkg::S_CMP_SCAN: begin
        if (rv) begin
          reg_we    = 1'b1;
          reg_waddr = ridx[RI-1:0];
          reg_wdata = {r_owner, r_size, next_addr[AW-1:0]};
        end else if (idx >= IW'(region_count) && free_units != '0) begin
          hole_we    = 1'b1;
          hole_wdata = {free_units, next_addr[AW-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= cra_pkg::S_IDLE;
      fit_policy   <= cra_pkg::FIT_FIRST;
      total_size   <= cra_pkg::SPACE_MAX;
      free_units   <= cra_pkg::SPACE_MAX;
      init_pend    <= 1'b1;
      hole_count   <= HC'(1);
      region_count <= '0;
      rv           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != cra_pkg::S_DONE) out_valid <= 1'b0;

      case (state)
        cra_pkg::S_IDLE: begin
          if (init_pend) init_pend <= 1'b0;
          if (accept) begin
            size_q     <= alloc_size;
            owner_q    <= owner;
            idx        <= '0;
            rv         <= 1'b0;
            found      <= 1'b0;
            have_lo    <= 1'b0;
            have_hi    <= 1'b0;
            pos        <= '0;
            next_addr  <= '0;
            res_addr   <= '0;
            case (func)
              cra_pkg::FN_REQUEST: begin
                if (region_count >= RC'(cra_pkg::MAX_REGIONS)) begin
                  res_status <= cra_pkg::ST_FULL;
                  state      <= cra_pkg::S_DONE;
                end else if (alloc_size == '0) begin
                  res_status <= cra_pkg::ST_NOFIT;
                  state      <= cra_pkg::S_DONE;
                end else begin
                  res_status <= cra_pkg::ST_OK;
                  state      <= cra_pkg::S_REQ_SCAN;
                end
              end
              cra_pkg::FN_RELEASE: begin
                res_status <= cra_pkg::ST_OK;
                state      <= cra_pkg::S_REL_RSCAN;
              end
              cra_pkg::FN_COMPACT: begin
                res_status <= cra_pkg::ST_OK;
                state      <= cra_pkg::S_CMP_SCAN;
              end
              default: begin
                res_status <= cra_pkg::ST_OK;
                state      <= cra_pkg::S_DONE;
              end
            endcase
          end
        end

        cra_pkg::S_REQ_SCAN: begin
          if (idx < IW'(hole_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[HI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv && h_fits) begin
            if ((fit_policy == cra_pkg::FIT_FIRST && !found) ||
                (fit_policy == cra_pkg::FIT_BEST && (!found || h_size < psize)) ||
                (fit_policy != cra_pkg::FIT_FIRST && fit_policy != cra_pkg::FIT_BEST &&
                 (!found || h_size > psize))) begin
              found  <= 1'b1;
              pick   <= ridx[HI-1:0];
              pstart <= h_start;
              psize  <= h_size;
            end
          end
          if (idx >= IW'(hole_count) && !rv) begin
            if (found) begin
              state <= cra_pkg::S_REQ_UPD;
            end else begin
              res_status <= cra_pkg::ST_NOFIT;
              state      <= cra_pkg::S_DONE;
            end
          end
        end

        cra_pkg::S_REQ_UPD: begin
          region_count <= region_count + RC'(1);
          free_units   <= free_units - size_q;
          res_addr     <= pstart;
          if (psize == size_q) begin
            idx   <= IW'(pick) + IW'(1);
            rv    <= 1'b0;
            state <= cra_pkg::S_HOLE_DROP;
          end else begin
            state <= cra_pkg::S_DONE;
          end
        end

        cra_pkg::S_REL_RSCAN: begin
          if (idx < IW'(region_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[RI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv && !found && r_owner == owner_q) begin
            found  <= 1'b1;
            rsel   <= ridx[RI-1:0];
            s_reg  <= r_start;
            sz_reg <= r_size;
          end
          if (idx >= IW'(region_count) && !rv) begin
            if (found) begin
              idx   <= '0;
              state <= cra_pkg::S_REL_HSCAN;
            end else begin
              res_status <= cra_pkg::ST_NOOWNER;
              state      <= cra_pkg::S_DONE;
            end
          end
        end

        cra_pkg::S_REL_HSCAN: begin
          if (idx < IW'(hole_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[HI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv) begin
            if (SW'(h_start) + h_size == SW'(s_reg)) begin
              have_lo  <= 1'b1;
              lo       <= ridx[HI-1:0];
              lo_start <= h_start;
              lo_size  <= h_size;
            end
            if (SW'(h_start) == SW'(s_reg) + sz_reg) begin
              have_hi <= 1'b1;
              hi      <= ridx[HI-1:0];
              hi_size <= h_size;
            end
            if (h_start < s_reg) pos <= pos + HC'(1);
          end
          if (idx >= IW'(hole_count) && !rv) begin
            if (!have_lo && !have_hi && hole_count >= HC'(cra_pkg::MAX_HOLES)) begin
              res_status <= cra_pkg::ST_FULL;
              state      <= cra_pkg::S_DONE;
            end else begin
              idx   <= IW'(rsel) + IW'(1);
              state <= cra_pkg::S_REG_SHIFT;
            end
          end
        end

        cra_pkg::S_REG_SHIFT: begin
          if (idx < IW'(region_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[RI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (idx >= IW'(region_count) && !rv) begin
            region_count <= region_count - RC'(1);
            state        <= cra_pkg::S_HACT;
          end
        end

        cra_pkg::S_HACT: begin
          free_units <= free_units + sz_reg;
          res_addr   <= s_reg;
          rv         <= 1'b0;
          if (have_lo && have_hi) begin
            idx   <= IW'(hi) + IW'(1);
            state <= cra_pkg::S_HOLE_DROP;
          end else if (have_lo || have_hi) begin
            state <= cra_pkg::S_DONE;
          end else begin
            idx   <= IW'(hole_count);
            state <= cra_pkg::S_HOLE_INS;
          end
        end

        cra_pkg::S_HOLE_DROP: begin
          if (idx < IW'(hole_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[HI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (idx >= IW'(hole_count) && !rv) begin
            hole_count <= hole_count - HC'(1);
            state      <= cra_pkg::S_DONE;
          end
        end

        // shift entries up from the top down to the insertion point
        cra_pkg::S_HOLE_INS: begin
          if (idx > IW'(pos)) begin
            idx  <= idx_m1;
            ridx <= XW'(idx_m1[HI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (idx <= IW'(pos) && !rv) begin
            hole_count <= hole_count + HC'(1);
            state      <= cra_pkg::S_DONE;
          end
        end

        cra_pkg::S_CMP_SCAN: begin
          if (idx < IW'(region_count)) begin
            idx  <= idx + IW'(1);
            ridx <= XW'(idx[RI-1:0]);
            rv   <= 1'b1;
          end else begin
            rv <= 1'b0;
          end
          if (rv) next_addr <= next_addr + r_size;
          if (idx >= IW'(region_count) && !rv) begin
            if (free_units == '0) begin
              hole_count <= '0;
              res_addr   <= '0;
            end else begin
              hole_count <= HC'(1);
              res_addr   <= next_addr[AW-1:0];
            end
            state <= cra_pkg::S_DONE;
          end
        end

        cra_pkg::S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            start_address <= (res_status == cra_pkg::ST_OK) ? res_addr : AW'(0);
            free_total    <= free_units;
            state         <= cra_pkg::S_IDLE;
          end
        end

        default: state <= cra_pkg::S_IDLE;
      endcase

      // configuration is written only while idle; a total_size write reinitialises the space
      if (cfg_we) begin
        if (cfg_index == cra_pkg::CFG_FIT_POLICY) begin
          fit_policy <= cfg_data[1:0];
        end else if (cfg_index == cra_pkg::CFG_TOTAL_SIZE) begin
          total_size   <= clamped;
          free_units   <= clamped;
          hole_count   <= HC'(1);
          region_count <= '0;
          init_pend    <= 1'b1;
        end
      end
    end
  end

  a_hole_count: assert property (@(posedge clk) disable iff (rst)
    hole_count <= HC'(cra_pkg::MAX_HOLES))
    else $error("hole count beyond table depth");

  a_region_count: assert property (@(posedge clk) disable iff (rst)
    region_count <= RC'(cra_pkg::MAX_REGIONS))
    else $error("region count beyond table depth");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_units <= total_size)
    else $error("free units exceed space size");

  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != cra_pkg::S_IDLE)
    else $error("accepted item did not start work");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == cra_pkg::S_DONE))
    else $error("result loaded outside completion");

endmodule
`default_nettype wire

>>> sv/cra_ram.sv
`default_nettype none
module cra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
